@@ rtl/rc4_pkg.sv @@
// Shared constants and types of the RC4 stream cipher unit.
package rc4_pkg;

  localparam int ByteW          = 8;
  localparam int BoxAw          = 8;
  localparam int BoxSize        = 256;
  localparam int KeyLenW        = 9;
  localparam int MaxKeyBytesDef = 256;

  localparam logic [ByteW-1:0]   ByteMask     = 8'hFF;
  localparam logic [KeyLenW-1:0] KeyLenReset  = 9'd16;

  typedef enum logic [1:0] {
    OpLoadKey  = 2'd0,
    OpSchedule = 2'd1,
    OpCrypt    = 2'd2
  } opcode_e;

  typedef struct packed {
    logic             we;
    logic [BoxAw-1:0] addr;
    logic [ByteW-1:0] data;
  } box_wr_t;

endpackage

@@ rtl/rc4_sbox_mem.sv @@
// State box memory with per-entry valid bits that make unwritten entries read as identity.
module rc4_sbox_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  rc4_pkg::box_wr_t          wr_i,
  input  logic [rc4_pkg::BoxAw-1:0] raddr_i,
  output logic [rc4_pkg::ByteW-1:0] rdata_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0]   mem_q [BoxSize];
  logic [BoxSize-1:0] valid_q;
  logic [ByteW-1:0]   rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_i.we) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // Write-first read: unless a clear is under way, a read of the entry being written returns the new value.
  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      rdata_q <= ByteW'(raddr_i);
    end else if (wr_i.we && (wr_i.addr == raddr_i)) begin
      rdata_q <= wr_i.data;
    end else if (valid_q[raddr_i]) begin
      rdata_q <= mem_q[raddr_i];
    end else begin
      rdata_q <= ByteW'(raddr_i);
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rc4_key_mem.sv @@
// Key byte store with one write port and one registered read port.
module rc4_key_mem #(
  parameter int Depth = rc4_pkg::MaxKeyBytesDef,
  parameter int Aw    = 8
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [Aw-1:0]             waddr_i,
  input  logic [rc4_pkg::ByteW-1:0] wdata_i,
  input  logic [Aw-1:0]             raddr_i,
  output logic [rc4_pkg::ByteW-1:0] rdata_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rc4_stream_cipher_unit.sv @@
// RC4 stream cipher unit: key store, state box memory and the read-modify-write sequencer.
//
// A key byte load leaves the unit idle and ready for the next transfer. A data
// byte runs through StJ, StSwap and StFin: the box memory has one read port, and
// each byte needs three dependent reads of it (entry i, entry j, then the
// keystream entry) while the two swap writes go out on its write port, the
// second one in the cycle that takes the next byte. The next byte is taken in
// StFin when the output register is free. The key schedule runs one swap pass
// per box entry through the same states and port, and the unit accepts nothing
// meanwhile. Refilling the box with the identity permutation is immediate
// through valid bits, so there is no clearing pass after reset.
module rc4_stream_cipher_unit #(
  parameter int MaxKeyBytes = rc4_pkg::MaxKeyBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rc4_pkg::KeyLenW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [rc4_pkg::ByteW-1:0]   key_index_i,
  input  logic [rc4_pkg::ByteW-1:0]   byte_value_i,
  input  logic                        end_of_stream_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rc4_pkg::ByteW-1:0]   out_byte_o,
  output logic                        last_o
);
  import rc4_pkg::*;

  localparam int KeyAw = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;
  localparam logic [KeyLenW-1:0] KeyMax = KeyLenW'(MaxKeyBytes);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StJ    = 4'b0010,
    StSwap = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic               ksa_q, ksa_d;
  logic [ByteW-1:0]   i_q, i_d;
  logic [ByteW-1:0]   j_q, j_d;
  logic [ByteW-1:0]   si_q, si_d;
  logic [ByteW-1:0]   t_q, t_d;
  logic [KeyAw-1:0]   pos_q, pos_d;
  logic [KeyLenW-1:0] key_length_q;
  logic [ByteW-1:0]   data_q;
  logic               eos_q;
  logic [ByteW-1:0]   out_byte_q;
  logic               last_q;
  logic               out_valid_q;

  logic               in_accept;
  logic               can_take;
  logic               out_free;
  logic               out_load;
  logic [ByteW-1:0]   keystream;
  logic [KeyLenW-1:0] len_eff;
  logic [KeyAw-1:0]   pos_next;

  box_wr_t            box_wr;
  logic               box_clear;
  logic [BoxAw-1:0]   box_raddr;
  logic [ByteW-1:0]   box_rdata;

  logic               key_we;
  logic [KeyAw-1:0]   key_raddr;
  logic [ByteW-1:0]   key_rdata;

  rc4_sbox_mem u_sbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (box_clear),
    .wr_i    (box_wr),
    .raddr_i (box_raddr),
    .rdata_o (box_rdata)
  );

  rc4_key_mem #(
    .Depth (MaxKeyBytes),
    .Aw    (KeyAw)
  ) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_index_i[KeyAw-1:0]),
    .wdata_i (byte_value_i),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign can_take   = (state_q == StIdle) || ((state_q == StFin) && !ksa_q && out_free);
  assign in_stall_o = !can_take;
  assign in_accept  = in_valid_i && can_take;

  // A length of zero behaves like one; lengths beyond the store are clipped.
  assign len_eff  = (key_length_q > KeyMax) ? KeyMax : key_length_q;
  assign pos_next = ((KeyLenW'(pos_q) + KeyLenW'(1)) >= len_eff) ? '0 : pos_q + KeyAw'(1);

  // The second swap write goes to entry j in the same cycle, so a keystream
  // read of that entry takes the swapped value directly.
  assign keystream = (t_q == j_q) ? si_q : box_rdata;

  always_comb begin
    state_d   = state_q;
    ksa_d     = ksa_q;
    i_d       = i_q;
    j_d       = j_q;
    si_d      = si_q;
    t_d       = t_q;
    pos_d     = pos_q;
    box_wr    = '0;
    box_clear = 1'b0;
    box_raddr = t_q;
    key_raddr = pos_q;
    key_we    = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      StIdle: begin
      end
      StJ: begin
        si_d      = box_rdata;
        j_d       = j_q + box_rdata + (ksa_q ? key_rdata : '0);
        box_raddr = j_d;
        state_d   = StSwap;
      end
      StSwap: begin
        box_wr    = '{we: 1'b1, addr: i_q, data: box_rdata};
        t_d       = si_q + box_rdata;
        box_raddr = t_d;
        state_d   = StFin;
      end
      StFin: begin
        box_wr = '{we: 1'b1, addr: j_q, data: si_q};
        if (ksa_q) begin
          if (i_q == ByteMask) begin
            i_d     = '0;
            j_d     = '0;
            state_d = StIdle;
          end else begin
            i_d       = i_q + ByteW'(1);
            box_raddr = i_d;
            pos_d     = pos_next;
            key_raddr = pos_next;
            state_d   = StJ;
          end
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (in_accept) begin
      unique case (opcode_e'(opcode_i))
        OpLoadKey: begin
          key_we = ({1'b0, key_index_i} < KeyMax);
        end
        OpSchedule: begin
          box_clear = 1'b1;
          ksa_d     = 1'b1;
          i_d       = '0;
          j_d       = '0;
          pos_d     = '0;
          box_raddr = '0;
          key_raddr = '0;
          state_d   = StJ;
        end
        OpCrypt: begin
          ksa_d     = 1'b0;
          i_d       = i_q + ByteW'(1);
          box_raddr = i_d;
          state_d   = StJ;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ksa_q        <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      pos_q        <= '0;
      key_length_q <= KeyLenReset;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ksa_q       <= ksa_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pos_q       <= pos_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (cfg_we_i) begin
        key_length_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    si_q <= si_d;
    t_q  <= t_d;
    if (in_accept && (opcode_e'(opcode_i) == OpCrypt)) begin
      data_q <= byte_value_i;
      eos_q  <= end_of_stream_i;
    end
    if (out_load) begin
      out_byte_q <= data_q ^ keystream;
      last_q     <= eos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  a_sched_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (opcode_i == OpSchedule)) |=> (state_q == StJ && ksa_q && i_q == '0 && j_q == '0))
    else $error("key schedule did not start from cleared indices");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !box_wr.we)
    else $error("box write while idle");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StFin && !ksa_q))
    else $error("result appeared without a finished data byte");

  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && ksa_q && i_q == ByteMask) |=> (state_q == StIdle && j_q == '0))
    else $error("key schedule did not end with cleared indices");

endmodule

@@ tb/rc4_stream_cipher_unit_tb.sv @@
// Self-checking testbench for the RC4 stream cipher unit with a cycle-free model of the cipher.
module rc4_stream_cipher_unit_tb;
  import rc4_pkg::*;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam int         SettleCycles = 800;
  localparam int         CycleLimit   = 400000;
  localparam int         HoldCycles   = 60;
  localparam int         MaxPrinted   = 40;
  localparam int         SessionItems = 40;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } cipher_out_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [KeyLenW-1:0] cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i        = OpLoadKey;
  logic [ByteW-1:0]   key_index_i     = '0;
  logic [ByteW-1:0]   byte_value_i    = '0;
  logic               end_of_stream_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [ByteW-1:0]   out_byte_o;
  logic               last_o;

  // Model state of the cipher.
  logic [ByteW-1:0]   sbox [BoxSize];
  logic [ByteW-1:0]   key_bytes [BoxSize];
  logic [ByteW-1:0]   idx_i;
  logic [ByteW-1:0]   idx_j;
  logic [KeyLenW-1:0] key_len;

  cipher_out_t expected_bytes [$];
  int          failures     = 0;
  int          printed      = 0;
  int          cycles       = 0;
  bit          quiet        = 1'b0;
  bit          hold_request = 1'b0;

  rc4_stream_cipher_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .key_index_i    (key_index_i),
    .byte_value_i   (byte_value_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic void fill_identity();
    for (int n = 0; n < BoxSize; n++) sbox[n] = n[ByteW-1:0];
  endfunction

  // Applies one accepted transfer to the model and queues the byte it produces.
  function automatic void predict_cipher(input logic [1:0] op, input logic [ByteW-1:0] kidx,
                                         input logic [ByteW-1:0] val, input logic eos);
    int               eff;
    int               pos;
    logic [ByteW-1:0] j;
    logic [ByteW-1:0] t;
    cipher_out_t      res;
    case (op)
      OpLoadKey: key_bytes[kidx] = val;
      OpSchedule: begin
        // A length of zero acts as one, anything past the store size as the full store.
        eff = (key_len == 0) ? 1 : ((key_len > BoxSize) ? BoxSize : int'(key_len));
        fill_identity();
        j   = '0;
        pos = 0;
        for (int n = 0; n < BoxSize; n++) begin
          j = j + sbox[n] + key_bytes[pos];
          pos++;
          if (pos >= eff) pos = 0;
          t       = sbox[n];
          sbox[n] = sbox[j];
          sbox[j] = t;
        end
        idx_i = '0;
        idx_j = '0;
      end
      OpCrypt: begin
        idx_i       = idx_i + 8'd1;
        idx_j       = idx_j + sbox[idx_i];
        t           = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = t;
        t           = sbox[idx_i] + sbox[idx_j];
        res.data    = val ^ sbox[t];
        res.last    = eos;
        expected_bytes.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    failures++;
    if (printed < MaxPrinted) begin
      $display("%0t: mismatch: %s", $time, msg);
      printed++;
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("rc4_stream_cipher_unit_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("output transfer with no byte pending");
      end else begin
        cipher_out_t want;
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o, want.data));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, expected %b", last_o, want.last));
      end
    end
  end

  // Output side: short random stalls, or one long hold on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [ByteW-1:0] kidx,
                           input logic [ByteW-1:0] val, input logic eos);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    key_index_i     <= kidx;
    byte_value_i    <= val;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    predict_cipher(op, kidx, val, eos);
  endtask

  task automatic send_crypt(input logic [ByteW-1:0] val, input logic eos);
    send_item(OpCrypt, rand_byte(), val, eos);
  endtask

  // The key schedule gives no output, so a fixed pause covers its run time.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_key_length(input logic [KeyLenW-1:0] len);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    key_len = len;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_crypt(8'h00, 1'b0);
    send_crypt(8'hFF, 1'b1);
    send_item(OpUnused, rand_byte(), rand_byte(), 1'b1);
    send_crypt(rand_byte(), 1'b0);
    send_crypt(rand_byte(), 1'b1);
  endtask

  task automatic test_short_keys();
    set_key_length(9'd1);
    send_item(OpLoadKey, 8'd0, 8'hFF, 1'b0);
    send_item(OpLoadKey, 8'd255, 8'h00, 1'b1);
    send_item(OpSchedule, rand_byte(), rand_byte(), rand_bit());
    repeat (3) send_crypt(rand_byte(), rand_bit());
    // Zero length falls back to key byte 0 on every pass.
    set_key_length(9'd0);
    send_item(OpLoadKey, 8'd0, 8'h5A, 1'b0);
    send_item(OpSchedule, rand_byte(), rand_byte(), rand_bit());
    send_crypt(8'hFF, 1'b1);
    send_crypt(8'h00, 1'b0);
  endtask

  task automatic test_full_key();
    set_key_length(9'd256);
    for (int k = 0; k < BoxSize; k++) send_item(OpLoadKey, k[ByteW-1:0], rand_byte(), rand_bit());
    send_item(OpSchedule, rand_byte(), rand_byte(), rand_bit());
    repeat (16) send_crypt(rand_byte(), rand_bit());
    set_key_length(9'd511);
    send_item(OpSchedule, rand_byte(), rand_byte(), rand_bit());
    repeat (8) send_crypt(rand_byte(), rand_bit());
  endtask

  task automatic test_back_pressure();
    hold_request = 1'b1;
    repeat (16) send_crypt(rand_byte(), rand_bit());
  endtask

  // Every key entry is written by now, so any key length is safe to schedule.
  task automatic test_random_sessions();
    int counted;
    int span;
    int r;
    logic [KeyLenW-1:0] len;
    for (int s = 0; s < 8; s++) begin
      case ($urandom_range(0, 9))
        0:       len = 9'd256;
        1:       len = 9'd0;
        2:       len = KeyLenW'($urandom_range(257, 511));
        3, 4:    len = KeyLenW'($urandom_range(33, 255));
        default: len = KeyLenW'($urandom_range(1, 32));
      endcase
      set_key_length(len);
      span = (len == 0) ? 1 : ((len > BoxSize) ? BoxSize : int'(len));
      counted = 0;
      repeat ($urandom_range(1, 8)) begin
        send_item(OpLoadKey, ByteW'($urandom_range(0, span - 1)), rand_byte(), rand_bit());
        counted++;
      end
      send_item(OpSchedule, rand_byte(), rand_byte(), rand_bit());
      counted++;
      while (counted < SessionItems) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          send_crypt(rand_byte(), $urandom_range(0, 7) == 0);
          counted++;
        end else if (r < 88) begin
          send_item(OpLoadKey, rand_byte(), rand_byte(), rand_bit());
          counted++;
        end else if (r < 91) begin
          send_item(OpSchedule, rand_byte(), rand_byte(), rand_bit());
          counted++;
        end else begin
          send_item(OpUnused, rand_byte(), rand_byte(), rand_bit());
        end
      end
    end
  endtask

  task automatic test_steady_stream();
    quiet = 1'b1;
    set_key_length(KeyLenW'($urandom_range(1, 256)));
    send_item(OpSchedule, rand_byte(), rand_byte(), rand_bit());
    repeat (60) send_crypt(rand_byte(), rand_bit());
  endtask

  initial begin
    fill_identity();
    idx_i   = '0;
    idx_j   = '0;
    key_len = KeyLenReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_short_keys();
    test_full_key();
    test_back_pressure();
    test_random_sessions();
    test_steady_stream();
    wait_idle();
    if (failures == 0) begin
      $display("rc4_stream_cipher_unit_tb passed");
    end else begin
      $display("rc4_stream_cipher_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rc4_pkg.sv
rtl/rc4_sbox_mem.sv
rtl/rc4_key_mem.sv
rtl/rc4_stream_cipher_unit.sv
tb/rc4_stream_cipher_unit_tb.sv
